@@ design/arrow_scanline_coverage_defines.svh @@
// Assertion macros shared by the arrow coverage RTL.
// Both macros sample on posedge clk and are disabled while rst_n is low.
`ifndef ARROW_SCANLINE_COVERAGE_DEFINES_SVH
`define ARROW_SCANLINE_COVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASC_ASSERT_NOW(lbl, ante, cons, msg)
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/asc_pkg.sv @@
package asc_pkg;

  localparam int COORD_W  = 12;
  localparam int QUO_W    = 12;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int COLOR_W  = 24;
  localparam int PX_W     = 8;
  localparam int PY_W     = 7;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 128;

  localparam logic [COLOR_W-1:0] BG_COLOR = 24'h0B1118;

  typedef enum logic [2:0] {
    REG_TOP_ROW            = 3'd0,
    REG_MIDDLE_ROW         = 3'd1,
    REG_BOTTOM_ROW         = 3'd2,
    REG_UPPER_SHOULDER_ROW = 3'd3,
    REG_LOWER_SHOULDER_ROW = 3'd4,
    REG_BASE_COLUMN        = 3'd5,
    REG_TIP_COLUMN         = 3'd6,
    REG_TAIL_COLUMN        = 3'd7
  } asc_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t top_row;
    coord_t middle_row;
    coord_t bottom_row;
    coord_t upper_shoulder_row;
    coord_t lower_shoulder_row;
    coord_t base_column;
    coord_t tip_column;
    coord_t tail_column;
  } asc_cfg_t;

  // Per-pixel data riding alongside the divider.
  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [PX_W-1:0]    px;
    coord_t             x0;
    coord_t             straight;
    logic               dx_neg;
    logic               hit;     // row in range and pixel inside buffer
    logic               zero;    // zero-height edge
  } asc_side_t;

  // Word passed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic [PROD_W-1:0]  rem;
    logic [QUO_W-1:0]   quo;
    logic [COORD_W-1:0] den;
    asc_side_t          side;
  } asc_cell_t;

endpackage

@@ design/asc_front.sv @@
`include "arrow_scanline_coverage_defines.svh"

module asc_front
  import asc_pkg::*;
#(
  parameter int WIDTH  = GRID_WIDTH,
  parameter int HEIGHT = GRID_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [PX_W-1:0]    in_pixel_x,
  input  logic [PY_W-1:0]    in_pixel_y,
  input  logic [COLOR_W-1:0] in_fg_color,
  input  asc_cfg_t           cfg,
  output asc_cell_t          cell_out
);

  localparam int EXT_W = COORD_W + 1;

  logic signed [EXT_W-1:0] py_s, top_s, mid_s, bot_s, ush_s, lsh_s;
  logic signed [EXT_W-1:0] y0_s, y1_s, x0_s, x1_s;
  logic signed [EXT_W-1:0] dy_s, den_s, dx_s, dx_abs_s;
  logic                    upper;
  asc_side_t               side_nxt;

  // stage A: operand setup
  logic                    sa_valid_r;
  asc_side_t               sa_side_r;
  logic [COORD_W-1:0]      sa_dx_r, sa_dy_r, sa_den_r;
  asc_cell_t               cell_r;

  always_comb begin
    py_s  = $signed({{(EXT_W-PY_W){1'b0}}, in_pixel_y});
    top_s = {cfg.top_row[COORD_W-1], cfg.top_row};
    mid_s = {cfg.middle_row[COORD_W-1], cfg.middle_row};
    bot_s = {cfg.bottom_row[COORD_W-1], cfg.bottom_row};
    ush_s = {cfg.upper_shoulder_row[COORD_W-1], cfg.upper_shoulder_row};
    lsh_s = {cfg.lower_shoulder_row[COORD_W-1], cfg.lower_shoulder_row};

    upper = (py_s <= mid_s);
    y0_s  = upper ? top_s : mid_s;
    y1_s  = upper ? mid_s : bot_s;
    x0_s  = upper ? {cfg.base_column[COORD_W-1], cfg.base_column}
                  : {cfg.tip_column[COORD_W-1], cfg.tip_column};
    x1_s  = upper ? {cfg.tip_column[COORD_W-1], cfg.tip_column}
                  : {cfg.base_column[COORD_W-1], cfg.base_column};

    dy_s     = py_s - y0_s;
    den_s    = y1_s - y0_s;
    dx_s     = x1_s - x0_s;
    dx_abs_s = dx_s[EXT_W-1] ? -dx_s : dx_s;

    side_nxt.fg       = in_fg_color;
    side_nxt.px       = in_pixel_x;
    side_nxt.x0       = x0_s[COORD_W-1:0];
    side_nxt.straight = (py_s >= ush_s && py_s <= lsh_s) ? cfg.tail_column
                                                         : cfg.base_column;
    side_nxt.dx_neg   = dx_s[EXT_W-1];
    side_nxt.hit      = (32'(in_pixel_x) < WIDTH) && (32'(in_pixel_y) < HEIGHT) &&
                        (py_s >= top_s) && (py_s <= bot_s);
    side_nxt.zero     = (den_s == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (adv) begin
      sa_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_side_r <= side_nxt;
      sa_dx_r   <= dx_abs_s[COORD_W-1:0];
      sa_dy_r   <= dy_s[COORD_W-1:0];
      sa_den_r  <= den_s[COORD_W-1:0];
    end
  end

  // stage B: magnitude product |dx| * dy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (adv) begin
      cell_r.valid <= sa_valid_r;
      cell_r.rem   <= sa_dx_r * sa_dy_r;
      cell_r.quo   <= '0;
      cell_r.den   <= sa_den_r;
      cell_r.side  <= sa_side_r;
    end
  end

  assign cell_out = cell_r;

  `ASC_ASSERT_NEXT(a_front_load, in_valid && adv, sa_valid_r, "accepted word not loaded")
  `ASC_ASSERT_NOW(a_front_dy_le_den, sa_valid_r && sa_side_r.hit && !sa_side_r.zero,
                  sa_dy_r <= sa_den_r, "row offset exceeds edge height")

endmodule

@@ design/asc_div_cell.sv @@
`include "arrow_scanline_coverage_defines.svh"

module asc_div_cell
  import asc_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  asc_cell_t cell_in,
  output asc_cell_t cell_out
);

  localparam int TRIAL_W = PROD_W + 1;

  logic [TRIAL_W-1:0] dvs, trial;
  logic               ge;
  asc_cell_t          cell_nxt, cell_r;

  // one restoring step: try den << BIT against the partial remainder
  always_comb begin
    dvs      = TRIAL_W'(cell_in.den) << BIT;
    trial    = {1'b0, cell_in.rem} - dvs;
    ge       = !trial[TRIAL_W-1];
    cell_nxt = cell_in;
    if (ge) begin
      cell_nxt.rem      = trial[PROD_W-1:0];
      cell_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

  `ASC_ASSERT_NOW(a_cell_rem_bound,
                  cell_r.valid && cell_r.side.hit && !cell_r.side.zero,
                  (({1'b0, cell_r.rem}) < (TRIAL_W'(cell_r.den) << BIT)),
                  "partial remainder out of range")

endmodule

@@ design/asc_finish.sv @@
module asc_finish
  import asc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  asc_cell_t          cell_in,
  output logic               out_valid,
  output logic               out_covered,
  output logic [COLOR_W-1:0] out_pixel_color
);

  localparam int SX_W = COORD_W + 2;

  logic signed [SX_W-1:0] q_s, x0_s, sloped_s, straight_s, px_s, lo_s, hi_s;
  logic                   cov;

  logic                   valid_r, covered_r;
  logic [COLOR_W-1:0]     color_r;

  always_comb begin
    q_s        = $signed({2'b00, cell_in.quo});
    x0_s       = {{2{cell_in.side.x0[COORD_W-1]}}, cell_in.side.x0};
    straight_s = {{2{cell_in.side.straight[COORD_W-1]}}, cell_in.side.straight};
    px_s       = $signed({{(SX_W-PX_W){1'b0}}, cell_in.side.px});
    if (cell_in.side.zero) begin
      sloped_s = x0_s;
    end else if (cell_in.side.dx_neg) begin
      sloped_s = x0_s - q_s;
    end else begin
      sloped_s = x0_s + q_s;
    end
    lo_s = (straight_s < sloped_s) ? straight_s : sloped_s;
    hi_s = (straight_s > sloped_s) ? straight_s : sloped_s;
    cov  = cell_in.side.hit && (px_s >= lo_s) && (px_s <= hi_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      covered_r <= cov;
      color_r   <= cov ? cell_in.side.fg : BG_COLOR;
    end
  end

  assign out_valid       = valid_r;
  assign out_covered     = covered_r;
  assign out_pixel_color = color_r;

endmodule

@@ design/arrow_scanline_coverage.sv @@
// Pipeline: a word accepted on the input passes through setup, multiply,
//   12 divider cells and the output register before it appears on out_valid.
// Throughput: one pixel per clock; the whole chain advances together and holds
//   only while a finished result is stalled on the output.
// Reset: synchronous, rst_n low; clears all valid flags and all eight geometry
//   registers to zero. The chain needs no flush after reset.
`include "arrow_scanline_coverage_defines.svh"

module arrow_scanline_coverage
  import asc_pkg::*;
#(
  parameter int WIDTH  = GRID_WIDTH,
  parameter int HEIGHT = GRID_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,

  // pixel request
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PX_W-1:0]    in_pixel_x,
  input  logic [PY_W-1:0]    in_pixel_y,
  input  logic [COLOR_W-1:0] in_fg_color,

  // pixel result
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_covered,
  output logic [COLOR_W-1:0] out_pixel_color,

  // geometry registers, write only
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Structure
  //   front : row range checks, edge selection (upper edge through the
  //           middle row, lower edge after it), operand differences, then
  //           the magnitude product |x1-x0| * (y-y0) in its own stage.
  //   cells : a chain of identical restoring-divide cells, one quotient bit
  //           each, MSB first. The quotient never exceeds |x1-x0|, so twelve
  //           cells cover it. Sign is reapplied afterwards, which gives
  //           truncation toward zero.
  //   finish: sloped x = x0 +/- quotient (or x0 for a zero-height edge),
  //           span test against the straight edge, color select.
  // --------------------------------------------------------------------------

  asc_cfg_t cfg_r;
  logic     adv;

  // Entire chain moves whenever the output register is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Config writes; the index is exactly wide enough for the eight registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (asc_reg_t'(cfg_index))
        REG_TOP_ROW:            cfg_r.top_row            <= cfg_data;
        REG_MIDDLE_ROW:         cfg_r.middle_row         <= cfg_data;
        REG_BOTTOM_ROW:         cfg_r.bottom_row         <= cfg_data;
        REG_UPPER_SHOULDER_ROW: cfg_r.upper_shoulder_row <= cfg_data;
        REG_LOWER_SHOULDER_ROW: cfg_r.lower_shoulder_row <= cfg_data;
        REG_BASE_COLUMN:        cfg_r.base_column        <= cfg_data;
        REG_TIP_COLUMN:         cfg_r.tip_column         <= cfg_data;
        REG_TAIL_COLUMN:        cfg_r.tail_column        <= cfg_data;
        default:                cfg_r                    <= cfg_r;
      endcase
    end
  end

  // chain[0] is the front's product stage; chain[QUO_W] feeds the finish.
  asc_cell_t chain [0:QUO_W];

  asc_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_fg_color (in_fg_color),
    .cfg         (cfg_r),
    .cell_out    (chain[0])
  );

  // Cell k resolves quotient bit QUO_W-1-k.
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    asc_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  asc_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cell_in         (chain[QUO_W]),
    .out_valid       (out_valid),
    .out_covered     (out_covered),
    .out_pixel_color (out_pixel_color)
  );

  // A held result must freeze the chain, or words in flight would be lost.
  `ASC_ASSERT_NOW(a_top_freeze, out_valid && out_stall, in_stall && !adv,
                  "chain advanced while result stalled")

endmodule
